// ===== rtl/core/cal_pkg.sv =====
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants of the cursor array list
// Field widths of the stream payload, command codes and the result record
// handed from the controller to the output register.
// ----------------------------------------------------------------------------
package cal_pkg;

	localparam int DEF_MAX_ENTRIES = 32;
	localparam int DEF_WORD_BITS   = 32;

	localparam int CMD_W       = 4;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 5;
	localparam int CURSOR_W    = 5;
	localparam int COUNT_W     = 6;
	localparam int CAP_W       = 6;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd20;

	typedef enum logic [CMD_W-1:0] {
		CMD_FIRST      = 4'd0,
		CMD_LAST       = 4'd1,
		CMD_PREV       = 4'd2,
		CMD_NEXT       = 4'd3,
		CMD_SET        = 4'd4,
		CMD_INS_BEFORE = 4'd5,
		CMD_INS_AFTER  = 4'd6,
		CMD_READ_CUR   = 4'd7,
		CMD_READ_IDX   = 4'd8,
		CMD_REPLACE    = 4'd9,
		CMD_ERASE      = 4'd10,
		CMD_CLEAR      = 4'd11
	} cmd_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic                read_valid;
		logic [CURSOR_W-1:0] cursor;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
		logic                is_full;
	} res_t;

endpackage

// ===== rtl/core/cal_store.sv =====
// ----------------------------------------------------------------------------
// cal_store: entry memory of the cursor array list
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cal_store #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/cal_ctrl.sv =====
// ----------------------------------------------------------------------------
// cal_ctrl: command sequencer of the cursor array list
// Holds count and cursor, drives the entry memory and moves entries one per
// cycle for inserts and erases. Keeps one finished result until taken.
// ----------------------------------------------------------------------------
module cal_ctrl
	import cal_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int WORD_BITS   = DEF_WORD_BITS,
	localparam int PW = $clog2(MAX_ENTRIES),
	localparam int CW = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     in_cmd,
	input  logic [VALUE_W-1:0]   in_value,
	input  logic [INDEX_W-1:0]   in_index,
	input  logic [CAP_W-1:0]     cap_limit,
	output logic                 res_valid,
	input  logic                 res_take,
	output res_t                 res,
	output logic                 mem_we,
	output logic [PW-1:0]        mem_waddr,
	output logic [WORD_BITS-1:0] mem_wdata,
	output logic [PW-1:0]        mem_raddr,
	input  logic [WORD_BITS-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_SHUP = 4'b0100,
		ST_SHDN = 4'b1000
	} state_t;

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [PW-1:0]        cur_q, cur_d;
	logic [PW-1:0]        wr_ptr_q, wr_ptr_d;
	logic [PW-1:0]        pos_q, pos_d;
	logic [WORD_BITS-1:0] val_q, val_d;
	logic                 pend_q;
	res_t                 pres_q;

	logic                 accept;
	logic                 finish;
	logic                 rd_ok;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] wval;
	logic [CW-1:0]        eff_lim;
	logic                 room;
	logic [CW-1:0]        ins_pos;
	logic [CW-1:0]        cur_ext;
	res_t                 res_d;

	assign in_ready = (state_q == ST_IDLE) && (!pend_q || res_take);
	assign accept   = in_valid && in_ready;
	assign wval     = WORD_BITS'(in_value);
	assign cur_ext  = CW'(cur_q);

	// The limit register is clamped to the store depth.
	assign eff_lim = (32'(cap_limit) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(cap_limit);
	assign room    = cnt_q < eff_lim;

	always_comb begin
		if (cnt_q == '0) begin
			ins_pos = '0;
		end else if (in_cmd == CMD_INS_AFTER) begin
			ins_pos = cur_ext + CW'(1);
		end else begin
			ins_pos = cur_ext;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cur_d     = cur_q;
		wr_ptr_d  = wr_ptr_q;
		pos_d     = pos_q;
		val_d     = val_q;
		mem_we    = 1'b0;
		mem_waddr = wr_ptr_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		finish    = 1'b0;
		rd_ok     = 1'b0;
		rd_word   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd) inside
						CMD_FIRST: begin
							cur_d  = '0;
							finish = 1'b1;
						end
						CMD_LAST: begin
							cur_d  = (cnt_q != '0) ? PW'(cnt_q - CW'(1)) : '0;
							finish = 1'b1;
						end
						CMD_PREV: begin
							if (cur_q != '0) begin
								cur_d = cur_q - 1'b1;
							end
							finish = 1'b1;
						end
						CMD_NEXT: begin
							if (cur_ext + CW'(1) < cnt_q) begin
								cur_d = cur_q + 1'b1;
							end
							finish = 1'b1;
						end
						CMD_SET: begin
							if (32'(in_index) < 32'(cnt_q)) begin
								cur_d = PW'(in_index);
							end
							finish = 1'b1;
						end
						CMD_INS_BEFORE, CMD_INS_AFTER: begin
							if (!room) begin
								finish = 1'b1;
							end else if (ins_pos == cnt_q) begin
								// Appending at the end needs no moves.
								mem_we    = 1'b1;
								mem_waddr = PW'(ins_pos);
								mem_wdata = wval;
								cnt_d     = cnt_q + CW'(1);
								cur_d     = PW'(ins_pos);
								finish    = 1'b1;
							end else begin
								mem_raddr = PW'(cnt_q - CW'(1));
								wr_ptr_d  = PW'(cnt_q);
								pos_d     = PW'(ins_pos);
								val_d     = wval;
								state_d   = ST_SHUP;
							end
						end
						CMD_READ_CUR: begin
							if (cnt_q != '0) begin
								mem_raddr = cur_q;
								state_d   = ST_READ;
							end else begin
								finish = 1'b1;
							end
						end
						CMD_READ_IDX: begin
							if (32'(in_index) < 32'(cnt_q)) begin
								mem_raddr = PW'(in_index);
								state_d   = ST_READ;
							end else begin
								finish = 1'b1;
							end
						end
						CMD_REPLACE: begin
							if (cnt_q != '0) begin
								mem_we    = 1'b1;
								mem_waddr = cur_q;
								mem_wdata = wval;
							end
							finish = 1'b1;
						end
						CMD_ERASE: begin
							if (cnt_q == '0) begin
								finish = 1'b1;
							end else if (cur_ext + CW'(1) < cnt_q) begin
								mem_raddr = cur_q + 1'b1;
								wr_ptr_d  = cur_q;
								state_d   = ST_SHDN;
							end else begin
								cnt_d  = cnt_q - CW'(1);
								cur_d  = (cur_q != '0) ? cur_q - 1'b1 : '0;
								finish = 1'b1;
							end
						end
						CMD_CLEAR: begin
							cnt_d  = '0;
							cur_d  = '0;
							finish = 1'b1;
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
			end
			ST_READ: begin
				rd_ok   = 1'b1;
				rd_word = mem_rdata;
				finish  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SHUP: begin
				mem_we    = 1'b1;
				mem_waddr = wr_ptr_q;
				if (wr_ptr_q == pos_q) begin
					// All later entries moved up: drop the new word into the gap.
					mem_wdata = val_q;
					cnt_d     = cnt_q + CW'(1);
					cur_d     = pos_q;
					finish    = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					wr_ptr_d = wr_ptr_q - 1'b1;
					if (wr_ptr_q - 1'b1 != pos_q) begin
						mem_raddr = wr_ptr_q - 1'b1 - 1'b1;
					end
				end
			end
			ST_SHDN: begin
				mem_we    = 1'b1;
				mem_waddr = wr_ptr_q;
				if (CW'(wr_ptr_q) + CW'(2) < cnt_q) begin
					mem_raddr = wr_ptr_q + 1'b1 + 1'b1;
					wr_ptr_d  = wr_ptr_q + 1'b1;
				end else begin
					cnt_d   = cnt_q - CW'(1);
					cur_d   = (cur_q != '0) ? cur_q - 1'b1 : '0;
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_d.read_value = 32'(rd_word);
		res_d.read_valid = rd_ok;
		res_d.cursor     = CURSOR_W'(cur_d);
		res_d.count      = COUNT_W'(cnt_d);
		res_d.is_empty   = (cnt_d == '0);
		res_d.is_full    = (cnt_d >= eff_lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			cur_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			cur_q   <= cur_d;
			if (finish) begin
				pend_q <= 1'b1;
			end else if (res_take) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_ptr_q <= wr_ptr_d;
		pos_q    <= pos_d;
		val_q    <= val_d;
		if (finish) begin
			pres_q <= res_d;
		end
	end

	assign res_valid = pend_q;
	assign res       = pres_q;

	a_cursor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (cur_q == '0))
		else $error("cursor not zero on an empty list");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (cur_ext < cnt_q))
		else $error("cursor beyond the last entry");

	a_no_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !pend_q)
		else $error("result pending while a command is in progress");

	a_shup_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHUP) |-> (wr_ptr_q >= pos_q))
		else $error("insert shift ran past the insert position");

endmodule

// ===== rtl/core/cursor_array_list.sv =====
// ----------------------------------------------------------------------------
// cursor_array_list: ordered word list with a cursor, held in a memory
// Accepts list commands on a request stream and answers each with exactly one
// result request carrying the word read, the cursor, the count and flags.
// ----------------------------------------------------------------------------
//
//   port group   dir   tdata (low bit first)                      tuser
//   s_axis       in    value[31:0], index[36:32], zero fill       cmd[3:0]
//   m_axis       out   read_value[31:0], cursor[36:32],           read_valid
//                      count[42:37], is_empty[43], is_full[44]
//   cfg          in    cfg_wdata = capacity_limit, taken when cfg_we is high
//
// Cursor moves, clear, replace, appends and refused commands finish in the
// cycle they are accepted; reads pass through a read state because of the
// registered memory read. Inserts and erases that move entries stay busy while
// the single write port moves one entry per cycle.
// Reset clears count and cursor, loads the limit with 20 and leaves the memory.
// A finished result waits in the controller while the output register is full.
//
module cursor_array_list
	import cal_pkg::*;
#(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int WORD_BITS   = DEF_WORD_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value, index
	input  logic [CMD_W-1:0]       s_axis_tuser,   // cmd
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // read_value, cursor, count, is_empty, is_full
	output logic                   m_axis_tuser,   // read_valid
	input  logic                   cfg_we,
	input  logic [CAP_W-1:0]       cfg_wdata
);

	localparam int PW = $clog2(MAX_ENTRIES);

	logic [CAP_W-1:0]     cap_q;
	logic                 res_valid;
	logic                 res_take;
	res_t                 res;
	res_t                 out_q;
	logic                 out_valid_q;
	logic                 mem_we;
	logic [PW-1:0]        mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [PW-1:0]        mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;

	// The limit register must only be written while no command is in progress (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	cal_ctrl #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WORD_BITS  (WORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_value (s_axis_tdata[VALUE_W-1:0]),
		.in_index (s_axis_tdata[VALUE_W+INDEX_W-1:VALUE_W]),
		.cap_limit(cap_q),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	cal_store #(
		.DEPTH(MAX_ENTRIES),
		.WIDTH(WORD_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register: it takes the controller's result whenever it is empty
	// or is being emptied in the same cycle.
	assign res_take = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.read_valid;
	assign m_axis_tdata  = {3'b000, out_q.is_full, out_q.is_empty, out_q.count,
	                        out_q.cursor, out_q.read_value};

endmodule
